// File: sv/sensor_poly_temperature_defines.svh
// Assertion macros used by spt_scale.
`ifndef SENSOR_POLY_TEMPERATURE_DEFINES_SVH
`define SENSOR_POLY_TEMPERATURE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/spt_pkg.sv
`default_nettype none
package spt_pkg;

  localparam int AW    = 16;  // reduced reading
  localparam int NW    = 85;  // signed numerator N = 100*T*5e18
  localparam int MW    = 84;  // |N| + half divisor
  localparam int XW    = 66;  // (|N| + half) >> 18
  localparam int XLW   = 60;  // x below the saturation limit
  localparam int QW    = 16;
  localparam int RW    = 61;
  localparam int CIDXW = 3;

  typedef logic [CIDXW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_K0 = 3'd0;
  localparam cfg_idx_t REG_K1 = 3'd1;
  localparam cfg_idx_t REG_K2 = 3'd2;
  localparam cfg_idx_t REG_K3 = 3'd3;
  localparam cfg_idx_t REG_K4 = 3'd4;

  // Term scales with their power-of-two part split off (shifted in the adder).
  localparam logic [34:0] C_K1   = 35'd30517578125;     // 5e14 = 5^15 << 14
  localparam logic [23:0] C_K2   = 24'd9765625;         // 1e10 = 5^10 << 10
  localparam logic [11:0] C_K3   = 12'd3125;            // 2e5  = 5^5  << 6
  localparam logic [45:0] C_K0   = 46'd57220458984375;  // 7.5e18 = 3*5^19 << 17
  // Divisor 5e18 = 5^19 << 18.
  localparam logic [44:0] C_D5   = 45'd19073486328125;
  localparam logic [45:0] C_D5X2 = 46'd38146972656250;
  localparam logic [61:0] C_HALF = 62'd2500000000000000000;
  localparam logic [59:0] C_LIM_P = 60'd625000000000000000;  // 32768 * 5^19
  localparam logic [59:0] C_LIM_N = 60'd625019073486328125;  // 32769 * 5^19
  localparam logic [15:0] C_RECIP = 16'd60446;               // floor(2^60 / 5^19)

  localparam logic [15:0] TEMP_MAX = 16'h7FFF;
  localparam logic [15:0] TEMP_MIN = 16'h8000;

  typedef struct packed {
    logic [15:0] k0;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [15:0] k3;
    logic [15:0] k4;
  } coef_t;

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] n;  // two's complement
  } poly_res_t;

endpackage
`default_nettype wire

// File: sv/spt_poly.sv
`default_nettype none
module spt_poly (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [spt_pkg::AW-1:0]       a_in,
  input  spt_pkg::coef_t               coef,
  output spt_pkg::poly_res_t           res
);
  import spt_pkg::*;

  logic v1, v2, v3, v4, v5;

  logic [AW-1:0] a1;
  logic [31:0]   a2_1, k1a_1;

  logic [47:0]   a3_2, k2a2_2;
  logic [63:0]   a4_2;
  logic [66:0]   t1_2;

  logic [63:0]   k3a3_3;
  logic [79:0]   t4_3;
  logic [71:0]   t2_3;
  logic [61:0]   c0_3;
  logic [66:0]   t1_3;

  logic [75:0]   t3_4;
  logic [82:0]   negs_4;
  logic [66:0]   t1_4;

  logic [NW-1:0] n5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1     <= a_in;
      a2_1   <= 32'(a_in) * 32'(a_in);
      k1a_1  <= 32'(coef.k1) * 32'(a_in);

      a3_2   <= 48'(a2_1) * 48'(a1);
      a4_2   <= 64'(a2_1) * 64'(a2_1);
      k2a2_2 <= 48'(coef.k2) * 48'(a2_1);
      t1_2   <= 67'(k1a_1) * 67'(C_K1);

      k3a3_3 <= 64'(coef.k3) * 64'(a3_2);
      t4_3   <= 80'(coef.k4) * 80'(a4_2);
      t2_3   <= 72'(k2a2_2) * 72'(C_K2);
      c0_3   <= 62'(coef.k0) * 62'(C_K0);
      t1_3   <= t1_2;

      // negative terms: k4*a^4 + 1e10*k2*a^2 + 7.5e18*k0
      t3_4   <= 76'(k3a3_3) * 76'(C_K3);
      negs_4 <= 83'(t4_3) + 83'({t2_3, 10'd0}) + 83'({c0_3, 17'd0});
      t1_4   <= t1_3;

      n5     <= NW'({t3_4, 6'd0}) + NW'({t1_4, 14'd0}) - NW'(negs_4);
    end
  end

  assign res.valid = v5;
  assign res.n     = n5;

endmodule
`default_nettype wire

// File: sv/spt_scale.sv
`default_nettype none
`include "sensor_poly_temperature_defines.svh"
module spt_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  spt_pkg::poly_res_t  pin,
  output logic                m_valid,
  output logic [15:0]         m_temp,
  output logic                m_sat
);
  import spt_pkg::*;

  logic v6, v7, v8, v9, v10, v11, v12;

  logic          neg6, neg7, neg8, neg9, neg10, neg11;
  logic [MW-1:0] mag6;
  logic [MW-1:0] biased;
  logic [XW-1:0] x7;
  logic          sat8, sat9, sat10, sat11;
  logic [XLW-1:0] x8, x9, x10;
  logic [47:0]   prod;
  logic [QW-1:0] qe9, qe10, qe11;
  logic [RW-1:0] qd10, r11;
  logic [QW:0]   q_fin;
  logic [15:0]   temp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
    end else if (ce) begin
      v6  <= pin.valid;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
    end
  end

  // Half the divisor added to the magnitude rounds ties away from zero.
  assign biased = mag6 + MW'(C_HALF);
  // Reciprocal estimate; low by at most one.
  assign prod   = 48'(x8[XLW-1:28]) * 48'(C_RECIP);
  assign q_fin  = (QW+1)'(qe11) + (QW+1)'(r11 >= RW'(C_D5));

  always_comb begin
    if (sat11) begin
      temp_next = neg11 ? TEMP_MIN : TEMP_MAX;
    end else if (neg11) begin
      temp_next = 16'(-q_fin);
    end else begin
      temp_next = q_fin[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      neg6  <= pin.n[NW-1];
      mag6  <= pin.n[NW-1] ? MW'(-pin.n) : MW'(pin.n);

      neg7  <= neg6;
      x7    <= biased[MW-1:18];

      neg8  <= neg7;
      sat8  <= x7 >= (neg7 ? XW'(C_LIM_N) : XW'(C_LIM_P));
      x8    <= x7[XLW-1:0];

      neg9  <= neg8;
      sat9  <= sat8;
      x9    <= x8;
      qe9   <= prod[47:32];

      neg10 <= neg9;
      sat10 <= sat9;
      x10   <= x9;
      qe10  <= qe9;
      qd10  <= RW'(qe9) * RW'(C_D5);

      neg11 <= neg10;
      sat11 <= sat10;
      qe11  <= qe10;
      r11   <= RW'(x10) - qd10;

      m_temp <= temp_next;
      m_sat  <= sat11;
    end
  end

  assign m_valid = v12;

  `SPT_ASSERT_IMP(a_rem_bound, clk, rst, v11 && !sat11, r11 < RW'(C_D5X2), "quotient estimate off by more than one")
  `SPT_ASSERT_IMP(a_q_range, clk, rst, v11 && !sat11, qe11 <= (neg11 ? 16'd32768 : 16'd32767), "unsaturated quotient out of range")
  `SPT_ASSERT_IMP(a_sat_rail, clk, rst, m_valid && m_sat, m_temp == TEMP_MAX || m_temp == TEMP_MIN, "saturated result not at a rail")
  `SPT_ASSERT_NXT(a_advance, clk, rst, ce && v11, m_valid, "result lost in last stage")

endmodule
`default_nettype wire

// File: sv/sensor_poly_temperature.sv
// Fourth-order calibration polynomial temperature converter. Each request on the
// s_ side carries a 24-bit raw conversion result (s_tdata) and a read-failure flag
// (s_tuser, a failed read counts as zero); the result on the m_ side is the
// temperature in signed hundredths of a degree C (m_tdata), rounded to nearest
// with ties away from zero, and a flag (m_tuser) set when the value was clipped to
// the 16-bit range. The five calibration words k0..k4 are written through the
// cfg_ port (index 0..4, other indexes ignored) and must only change while no
// request is in flight. One request is taken every cycle unless m_tready stalls the
// output; each result passes through the register stages of the multiplier chain
// (five stages) and the reciprocal-divide, round and clip path (seven stages).
// A stall on m_tready holds the whole pipeline; s_tready stays high while the
// output register is empty or being taken, and is low during reset.
`default_nettype none
module sensor_poly_temperature (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // [23:0] adc_raw
  input  logic [0:0]                  s_tuser,   // [0] read_failed
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [15:0] temp_centi
  output logic [0:0]                  m_tuser,   // [0] saturated
  input  logic                        cfg_wen,
  input  logic [spt_pkg::CIDXW-1:0]   cfg_index,
  input  logic [15:0]                 cfg_data
);
  import spt_pkg::*;

  coef_t         coef;
  logic          ce;
  logic [AW-1:0] a_in;
  poly_res_t     pres;
  logic          sat_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_K0: coef.k0 <= cfg_data;
        REG_K1: coef.k1 <= cfg_data;
        REG_K2: coef.k2 <= cfg_data;
        REG_K3: coef.k3 <= cfg_data;
        REG_K4: coef.k4 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce && !rst;
  assign a_in     = s_tuser[0] ? '0 : s_tdata[23:8];

  spt_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .a_in     (a_in),
    .coef     (coef),
    .res      (pres)
  );

  spt_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .pin     (pres),
    .m_valid (m_tvalid),
    .m_temp  (m_tdata),
    .m_sat   (sat_out)
  );

  assign m_tuser[0] = sat_out;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import spt_pkg::*;

  localparam int PIPE_LAT    = 16;    // pipeline plus margin
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  localparam coef_t TYPICAL_COEFS = '{k0: 16'd40781, k1: 16'd32791, k2: 16'd36016,
                                      k3: 16'd24926, k4: 16'd28446};

  typedef struct packed {
    logic [23:0] raw;
    logic        failed;
  } reading_t;

  typedef struct packed {
    logic [15:0] temp;
    logic        sat;
  } temp_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_wen = 1'b0;
  cfg_idx_t    cfg_index = REG_K0;
  logic [15:0] cfg_data = '0;

  reading_t  reading_q[$];     // readings waiting to be sent
  temp_res_t temp_exp_q[$];    // expected temperatures, oldest first
  coef_t     coefs = '0;       // calibration words as the block should hold them
  reading_t  drv_reading;
  int        snd_idle_pct = 19;
  int        rcv_idle_pct = 19;
  int        n_errors = 0;
  int        hold_left = 0;
  bit        hold_done = 0;
  int        quiet_cycles = 0;

  sensor_poly_temperature uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // 100*T = N / 5e18, N = 2e5*k3*a^3 + 5e14*k1*a - (k4*a^4 + 1e10*k2*a^2 + 7.5e18*k0)
  function automatic temp_res_t calc_temperature(input reading_t rd, input coef_t c);
    logic [127:0] a, a2, a3, a4, pos, neg, mag, q;
    logic         below;
    temp_res_t    r;
    a   = rd.failed ? 128'd0 : 128'(rd.raw[23:8]);
    a2  = a * a;
    a3  = a2 * a;
    a4  = a2 * a2;
    pos = 128'd200000 * c.k3 * a3 + 128'd500000000000000 * c.k1 * a;
    neg = a4 * c.k4 + 128'd10000000000 * c.k2 * a2 + 128'd7500000000000000000 * c.k0;
    below = pos < neg;
    mag = below ? neg - pos : pos - neg;
    // ties go away from zero
    q = (mag + 128'd2500000000000000000) / 128'd5000000000000000000;
    r.sat = 1'b0;
    if (below) begin
      if (q > 128'd32768) begin
        r.temp = TEMP_MIN;
        r.sat  = 1'b1;
      end else begin
        r.temp = 16'(-q);
      end
    end else begin
      if (q > 128'd32767) begin
        r.temp = TEMP_MAX;
        r.sat  = 1'b1;
      end else begin
        r.temp = q[15:0];
      end
    end
    return r;
  endfunction

  function automatic void add_reading(input logic [23:0] raw, input logic failed);
    reading_t rd;
    rd.raw    = raw;
    rd.failed = failed;
    reading_q.push_back(rd);
  endfunction

  function automatic reading_t rand_reading();
    reading_t rd;
    rd.raw = 24'($urandom);
    if ($urandom_range(0, 9) == 0)
      rd.raw = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'($urandom_range(0, 255));
    rd.failed = ($urandom_range(0, 9) == 0);
    return rd;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_K0: coefs.k0 = data;
      REG_K1: coefs.k1 = data;
      REG_K2: coefs.k2 = data;
      REG_K3: coefs.k3 = data;
      REG_K4: coefs.k4 = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic load_coefs(input coef_t c);
    write_reg(REG_K0, c.k0);
    write_reg(REG_K1, c.k1);
    write_reg(REG_K2, c.k2);
    write_reg(REG_K3, c.k3);
    write_reg(REG_K4, c.k4);
  endtask

  // unused register indexes must leave the calibration alone
  task automatic write_unused_regs();
    for (int i = int'(REG_K4) + 1; i < 2 ** CIDXW; i++)
      write_reg(cfg_idx_t'(i), 16'($urandom));
  endtask

  task automatic wait_drained();
    while (reading_q.size() != 0 || s_tvalid || temp_exp_q.size() != 0)
      @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        temp_exp_q.push_back(calc_temperature(drv_reading, coefs));
      if (!s_tvalid || s_tready) begin
        if (reading_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          drv_reading = reading_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= drv_reading.raw;
          s_tuser  <= drv_reading.failed;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    temp_res_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (temp_exp_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none actual temp %0d sat %0d",
                   $time, $signed(m_tdata), m_tuser[0]);
        end else begin
          exp_res = temp_exp_q.pop_front();
          if (m_tdata !== exp_res.temp) begin
            n_errors++;
            $display("%0t: temp_centi mismatch, expected %0d actual %0d",
                     $time, $signed(exp_res.temp), $signed(m_tdata));
          end
          if (m_tuser[0] !== exp_res.sat) begin
            n_errors++;
            $display("%0t: saturated mismatch, expected %0d actual %0d",
                     $time, exp_res.sat, m_tuser[0]);
          end
        end
      end
      // one long hold while a full batch is queued, so the pipeline backs up
      if (!hold_done && reading_q.size() >= 40) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    coef_t c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // calibration still at reset: everything reads zero
    @(negedge clk);
    add_reading(24'h000000, 1'b0);
    add_reading(24'hFFFFFF, 1'b0);
    add_reading(24'hFFFFFF, 1'b1);

    // plausible factory calibration across the raw range
    wait_drained();
    load_coefs(TYPICAL_COEFS);
    @(negedge clk);
    add_reading(24'h000000, 1'b0);
    add_reading(24'h0000FF, 1'b0);
    add_reading(24'h000100, 1'b0);
    add_reading(24'h7FFFFF, 1'b0);
    add_reading(24'h800000, 1'b0);
    add_reading(24'h5A5A5A, 1'b0);
    add_reading(24'hA5A5A5, 1'b0);
    add_reading(24'hFFFFFF, 1'b0);
    add_reading(24'hFFFFFF, 1'b1);
    add_reading(24'h3C1234, 1'b0);

    // all words at max: clips high at full scale, low on a failed read
    wait_drained();
    load_coefs('1);
    @(negedge clk);
    add_reading(24'h000000, 1'b0);
    add_reading(24'hFFFFFF, 1'b0);
    add_reading(24'h800000, 1'b0);
    add_reading(24'h123456, 1'b1);

    // constant term only, odd k0 gives exact halves (-1.5, -4.5)
    wait_drained();
    c = '0;
    c.k0 = 16'd1;
    load_coefs(c);
    write_unused_regs();
    @(negedge clk);
    add_reading(24'h123456, 1'b1);
    add_reading(24'hFFFFFF, 1'b0);
    wait_drained();
    write_reg(REG_K0, 16'd3);
    @(negedge clk);
    add_reading(24'h000000, 1'b0);
    add_reading(24'hABCDEF, 1'b1);

    // random batches: near-typical calibration alternates with arbitrary words
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p % 2 == 0) begin
        c.k0 = 16'(TYPICAL_COEFS.k0 + $urandom_range(0, 4095) - 2048);
        c.k1 = 16'(TYPICAL_COEFS.k1 + $urandom_range(0, 4095) - 2048);
        c.k2 = 16'(TYPICAL_COEFS.k2 + $urandom_range(0, 4095) - 2048);
        c.k3 = 16'(TYPICAL_COEFS.k3 + $urandom_range(0, 4095) - 2048);
        c.k4 = 16'(TYPICAL_COEFS.k4 + $urandom_range(0, 4095) - 2048);
      end else begin
        c = coef_t'({$urandom, $urandom, $urandom});
      end
      load_coefs(c);
      if (p == 3)
        write_unused_regs();
      @(negedge clk);
      // one batch runs back to back on both sides
      snd_idle_pct <= (p == 2) ? 0 : 19;
      rcv_idle_pct <= (p == 2) ? 0 : 19;
      repeat (63) reading_q.push_back(rand_reading());
    end

    wait_drained();
    if (temp_exp_q.size() != 0)
      n_errors++;
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
